// ===== rtl/rlb_pkg.sv =====
// Shared types, constants and helper functions for the refinement level balance pipeline.
`timescale 1ns / 1ps

package rlb_pkg;

    localparam int LEVEL_BITS = 4;
    localparam int NUM_DIRS   = 3;
    localparam int NUM_TAN    = 4;

    // conflict fix passes; three zero enough levels for a cell or a direction to run dry
    localparam int NUM_PASSES = 3;

    // mode codes
    localparam logic MODE_TWO_SIDED = 1'b0;
    localparam logic MODE_ONE_SIDED = 1'b1;

    // direction indexes
    localparam int DIR_ALPHA = 0;
    localparam int DIR_BETA  = 1;
    localparam int DIR_GAMMA = 2;

    // slots of the four tangential levels
    localparam int TAN_CELL_A = 0;
    localparam int TAN_CELL_B = 1;
    localparam int TAN_NEI_A  = 2;
    localparam int TAN_NEI_B  = 3;

    // last face index of each tangential pair
    localparam logic [2:0] FACE_LAST_AB = 3'd1;
    localparam logic [2:0] FACE_LAST_BG = 3'd3;
    localparam logic [2:0] FACE_LAST_AG = 3'd5;

    typedef logic [LEVEL_BITS-1:0] rlb_level_t;

    typedef enum logic [1:0] {
        PAIR_AB,
        PAIR_BG,
        PAIR_AG,
        PAIR_NONE
    } rlb_pair_t;

    // one input word as it enters the pipeline
    typedef struct packed {
        logic                         mode;
        logic [2:0]                   face;
        rlb_level_t [NUM_DIRS-1:0]    c;
        rlb_level_t [NUM_DIRS-1:0]    n;
    } rlb_input_t;

    // working item carried between the stages
    typedef struct packed {
        logic                         mode;
        rlb_pair_t                    pair;
        rlb_level_t [NUM_DIRS-1:0]    c0;
        rlb_level_t [NUM_DIRS-1:0]    n0;
        rlb_level_t [NUM_DIRS-1:0]    c;
        rlb_level_t [NUM_DIRS-1:0]    n;
        rlb_level_t [NUM_TAN-1:0]     v;
        rlb_level_t                   total;
        logic                         done;
    } rlb_item_t;

    // one result word
    typedef struct packed {
        rlb_level_t [NUM_DIRS-1:0]    c;
        rlb_level_t [NUM_DIRS-1:0]    n;
        logic                         changed;
    } rlb_result_t;

    // first direction index of a tangential pair
    function automatic int pair_dir_a(input rlb_pair_t pair);
        case (pair)
            PAIR_AB: pair_dir_a = DIR_ALPHA;
            PAIR_BG: pair_dir_a = DIR_BETA;
            PAIR_AG: pair_dir_a = DIR_ALPHA;
            default: pair_dir_a = DIR_ALPHA;
        endcase
    endfunction

    // second direction index of a tangential pair
    function automatic int pair_dir_b(input rlb_pair_t pair);
        case (pair)
            PAIR_AB: pair_dir_b = DIR_BETA;
            PAIR_BG: pair_dir_b = DIR_GAMMA;
            PAIR_AG: pair_dir_b = DIR_GAMMA;
            default: pair_dir_b = DIR_BETA;
        endcase
    endfunction

endpackage

// ===== rtl/refinement_level_balance.sv =====
// Top level of the refinement level balance pipeline.
//
// Usage: one word per shared face enters on the s_ channel (valid/ready):
// mode, face index, the cell's three levels and the neighbor's three levels
// in the cell frame. One result word leaves on the m_ channel (valid/ready)
// with the six balanced levels and a changed flag.
// The pipeline has five register stages: the 2:1 rule, three passes of the
// conflict fix (at most three passes can subtract anything before a cell or
// a direction runs dry) and the final raise and compare.
// Throughput is one word per cycle while m_ready is high; every stage holds
// one word and moves it on whenever the next stage is empty or moving.
// Reset (aresetn low at a clock edge) clears all valid bits; words in flight
// are dropped. When the receiver holds m_ready low the result stays on the
// port, the stages fill up behind it, and s_ready falls once all five stages
// are full; nothing is lost or repeated.
`timescale 1ns / 1ps

module refinement_level_balance (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [2:0]                s_face_index,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_cell_alpha,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_cell_beta,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_cell_gamma,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_nei_alpha,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_nei_beta,
    input  logic [rlb_pkg::LEVEL_BITS-1:0] s_nei_gamma,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_cell_alpha,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_cell_beta,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_cell_gamma,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_nei_alpha,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_nei_beta,
    output logic [rlb_pkg::LEVEL_BITS-1:0] m_new_nei_gamma,
    output logic                      m_changed
);

    rlb_pkg::rlb_input_t  in_word;
    rlb_pkg::rlb_result_t out_word;
    rlb_pkg::rlb_item_t   item   [rlb_pkg::NUM_PASSES+1];
    logic                 valid  [rlb_pkg::NUM_PASSES+1];
    logic                 ready  [rlb_pkg::NUM_PASSES+1];

    // pack the input word
    always_comb begin
        in_word.mode = s_mode;
        in_word.face = s_face_index;
        in_word.c[rlb_pkg::DIR_ALPHA] = s_cell_alpha;
        in_word.c[rlb_pkg::DIR_BETA]  = s_cell_beta;
        in_word.c[rlb_pkg::DIR_GAMMA] = s_cell_gamma;
        in_word.n[rlb_pkg::DIR_ALPHA] = s_nei_alpha;
        in_word.n[rlb_pkg::DIR_BETA]  = s_nei_beta;
        in_word.n[rlb_pkg::DIR_GAMMA] = s_nei_gamma;
    end

    rlb_balance u_balance (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (in_word),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_item  (item[0])
    );

    // chain of conflict passes
    for (genvar p = 0; p < rlb_pkg::NUM_PASSES; p++) begin : g_pass
        rlb_pass u_pass (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[p]),
            .in_ready  (ready[p]),
            .in_item   (item[p]),
            .out_valid (valid[p+1]),
            .out_ready (ready[p+1]),
            .out_item  (item[p+1])
        );
    end

    rlb_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid[rlb_pkg::NUM_PASSES]),
        .in_ready  (ready[rlb_pkg::NUM_PASSES]),
        .in_item   (item[rlb_pkg::NUM_PASSES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    // unpack the result word
    assign m_new_cell_alpha = out_word.c[rlb_pkg::DIR_ALPHA];
    assign m_new_cell_beta  = out_word.c[rlb_pkg::DIR_BETA];
    assign m_new_cell_gamma = out_word.c[rlb_pkg::DIR_GAMMA];
    assign m_new_nei_alpha  = out_word.n[rlb_pkg::DIR_ALPHA];
    assign m_new_nei_beta   = out_word.n[rlb_pkg::DIR_BETA];
    assign m_new_nei_gamma  = out_word.n[rlb_pkg::DIR_GAMMA];
    assign m_changed        = out_word.changed;

endmodule

// ===== rtl/rlb_balance.sv =====
// First stage: per-direction 2:1 rule and selection of the tangential levels.
`timescale 1ns / 1ps

module rlb_balance (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rlb_pkg::rlb_input_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rlb_pkg::rlb_item_t  out_item
);

    logic               valid_reg;
    rlb_pkg::rlb_item_t item_reg;
    rlb_pkg::rlb_item_t item_next;

    // advance when the stage is empty or its word moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // apply the 2:1 rule and gather the tangential levels
    always_comb begin
        logic [rlb_pkg::LEVEL_BITS:0] cw;
        logic [rlb_pkg::LEVEL_BITS:0] nw;
        int                           da;
        int                           db;
        item_next       = '0;
        item_next.mode  = in_word.mode;
        item_next.c0    = in_word.c;
        item_next.n0    = in_word.n;
        item_next.c     = in_word.c;
        item_next.n     = in_word.n;
        for (int d = 0; d < rlb_pkg::NUM_DIRS; d++) begin
            cw = {1'b0, in_word.c[d]};
            nw = {1'b0, in_word.n[d]};
            if (nw > cw + 1'b1) begin
                item_next.c[d] = in_word.n[d] - 1'b1;
            end else if (in_word.mode == rlb_pkg::MODE_TWO_SIDED && cw > nw + 1'b1) begin
                item_next.n[d] = in_word.c[d] - 1'b1;
            end
        end
        if (in_word.face <= rlb_pkg::FACE_LAST_AB) begin
            item_next.pair = rlb_pkg::PAIR_AB;
        end else if (in_word.face <= rlb_pkg::FACE_LAST_BG) begin
            item_next.pair = rlb_pkg::PAIR_BG;
        end else if (in_word.face <= rlb_pkg::FACE_LAST_AG) begin
            item_next.pair = rlb_pkg::PAIR_AG;
        end else begin
            item_next.pair = rlb_pkg::PAIR_NONE;
        end
        da = rlb_pkg::pair_dir_a(item_next.pair);
        db = rlb_pkg::pair_dir_b(item_next.pair);
        item_next.v[rlb_pkg::TAN_CELL_A] = item_next.c[da];
        item_next.v[rlb_pkg::TAN_CELL_B] = item_next.c[db];
        item_next.v[rlb_pkg::TAN_NEI_A]  = item_next.n[da];
        item_next.v[rlb_pkg::TAN_NEI_B]  = item_next.n[db];
        item_next.total = '0;
        // no tangential pair: skip the conflict fix
        item_next.done  = (item_next.pair == rlb_pkg::PAIR_NONE);
    end

    // hold the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // load the word
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/rlb_pass.sv =====
// One pass of the conflict fix: subtract the least nonzero tangential level.
`timescale 1ns / 1ps

module rlb_pass (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rlb_pkg::rlb_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rlb_pkg::rlb_item_t out_item
);

    logic                logic_stop;
    logic                valid_reg;
    rlb_pkg::rlb_item_t  item_reg;
    rlb_pkg::rlb_item_t  item_next;
    rlb_pkg::rlb_level_t least;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // stop once a cell or a direction has both levels at zero
    always_comb begin
        logic [rlb_pkg::NUM_TAN-1:0] z;
        for (int i = 0; i < rlb_pkg::NUM_TAN; i++) begin
            z[i] = (in_item.v[i] == '0);
        end
        logic_stop = in_item.done
            || (z[rlb_pkg::TAN_CELL_A] && z[rlb_pkg::TAN_CELL_B])
            || (z[rlb_pkg::TAN_NEI_A]  && z[rlb_pkg::TAN_NEI_B])
            || (z[rlb_pkg::TAN_CELL_A] && z[rlb_pkg::TAN_NEI_A])
            || (z[rlb_pkg::TAN_CELL_B] && z[rlb_pkg::TAN_NEI_B]);
    end

    // find the least nonzero level
    always_comb begin
        logic found;
        found = 1'b0;
        least = '0;
        for (int i = 0; i < rlb_pkg::NUM_TAN; i++) begin
            if (in_item.v[i] != '0 && (!found || in_item.v[i] < least)) begin
                least = in_item.v[i];
                found = 1'b1;
            end
        end
    end

    // unless stopped, subtract it from all four and add it to the total
    always_comb begin
        item_next = in_item;
        if (logic_stop) begin
            item_next.done = 1'b1;
        end else begin
            item_next.total = in_item.total + least;
            for (int i = 0; i < rlb_pkg::NUM_TAN; i++) begin
                item_next.v[i] = (in_item.v[i] > least) ? in_item.v[i] - least : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    // a finished word keeps its total
    a_done_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_item.done) |=> (out_item.total == $past(in_item.total)))
        else $error("conflict total changed after the fix finished");

    // a live pass always grows the total
    a_live_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && !logic_stop) |=> (out_item.total > $past(in_item.total)))
        else $error("conflict pass did not grow the total");

    // an accepted word shows up at the stage output
    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted word lost in conflict pass");

endmodule

// ===== rtl/rlb_finish.sv =====
// Last stage: raise the tangential levels to the total and flag changes.
`timescale 1ns / 1ps

module rlb_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rlb_pkg::rlb_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rlb_pkg::rlb_result_t out_word
);

    logic                 valid_reg;
    rlb_pkg::rlb_result_t word_reg;
    rlb_pkg::rlb_result_t word_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // raise, restore the neighbor in one-sided mode, compare
    always_comb begin
        logic [rlb_pkg::NUM_DIRS-1:0] tan;
        logic                         chg;
        tan = '0;
        chg = 1'b0;
        if (in_item.pair != rlb_pkg::PAIR_NONE) begin
            tan[rlb_pkg::pair_dir_a(in_item.pair)] = 1'b1;
            tan[rlb_pkg::pair_dir_b(in_item.pair)] = 1'b1;
        end
        word_next = '0;
        for (int d = 0; d < rlb_pkg::NUM_DIRS; d++) begin
            word_next.c[d] = (tan[d] && in_item.c[d] < in_item.total)
                ? in_item.total : in_item.c[d];
            word_next.n[d] = (tan[d] && in_item.n[d] < in_item.total)
                ? in_item.total : in_item.n[d];
            if (in_item.mode == rlb_pkg::MODE_ONE_SIDED) begin
                word_next.n[d] = in_item.n0[d];
            end
            if (word_next.c[d] != in_item.c0[d] || word_next.n[d] != in_item.n0[d]) begin
                chg = 1'b1;
            end
        end
        word_next.changed = chg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= word_next;
        end
    end

endmodule
